### sv/sh24_pkg.sv
// Shared types, constants and the SipRound function for the SipHash-2-4 core.
`timescale 1ns / 1ps

package sh24_pkg;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned ADDR_W      = 5;
    localparam int unsigned QUEUE_DEPTH = 4;

    // register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_KEY_LOW   = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH  = 2'd1;
    localparam logic [1:0] REG_FOLD_CASE = 2'd2;

    localparam logic [WORD_W-1:0] SIP_INIT0     = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] SIP_INIT1     = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] SIP_INIT2     = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] SIP_INIT3     = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] SIP_FINAL_XOR = 64'h00000000000000ff;

    typedef logic [3:0][WORD_W-1:0] sh24_state_t;

    // one request for the back end
    typedef struct packed {
        logic              start;   // load chain words from key first
        logic              absorb;  // absorb word as a full block
        logic              fin;     // finalise with length/tail block
        logic [7:0]        len;     // message length mod 256
        logic [WORD_W-1:0] word;    // folded, masked message bytes
    } sh24_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sh24_qstat_t;

    typedef struct packed {
        logic pop;
        logic res_write;
    } sh24_estat_t;

    function automatic sh24_state_t sip_round(input sh24_state_t v);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        sh24_state_t       r;
        a = v[0];
        b = v[1];
        c = v[2];
        d = v[3];
        a = a + b;
        b = {b[50:0], b[63:51]};
        b = b ^ a;
        a = {a[31:0], a[63:32]};
        c = c + d;
        d = {d[47:0], d[63:48]};
        d = d ^ c;
        a = a + d;
        d = {d[42:0], d[63:43]};
        d = d ^ a;
        c = c + b;
        b = {b[46:0], b[63:47]};
        b = b ^ c;
        c = {c[31:0], c[63:32]};
        r[0] = a;
        r[1] = b;
        r[2] = c;
        r[3] = d;
        return r;
    endfunction

endpackage

### sv/sh24_front.sv
// Front end: accepts message words, folds and masks bytes, tracks length, builds requests.
`timescale 1ns / 1ps

module sh24_front
    import sh24_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [WORD_W-1:0] data_word,
    input  logic [3:0]        byte_count,
    input  logic              last_word,
    input  logic              fold_case,
    input  sh24_qstat_t       q_stat,
    output logic              q_write,
    output sh24_cmd_t         q_cmd
);

    logic              open_reg;
    logic              open_next;
    logic [7:0]        len_reg;
    logic [7:0]        len_next;
    logic [7:0]        len_sum;
    logic [3:0]        count;
    logic              is_full;
    logic              closes;
    logic [WORD_W-1:0] word_fm;

    assign is_full = byte_count[3];
    assign count   = is_full ? 4'd8 : byte_count;
    assign closes  = !is_full || last_word;
    assign len_sum = (open_reg ? len_reg : 8'd0) + {4'd0, count};
    assign q_write = push && !q_stat.full;

    // fold upper case and drop bytes beyond the count
    always_comb
    begin
        logic [7:0] b;
        for (int i = 0; i < 8; i++)
        begin
            b = data_word[8*i +: 8];
            if (fold_case && b >= 8'h41 && b <= 8'h5a)
            begin
                b = b + 8'h20;
            end
            if (!is_full && !(3'(i) < byte_count[2:0]))
            begin
                b = 8'h00;
            end
            word_fm[8*i +: 8] = b;
        end
    end

    always_comb
    begin
        q_cmd.start  = !open_reg;
        q_cmd.absorb = is_full;
        q_cmd.fin    = closes;
        q_cmd.len    = len_sum;
        q_cmd.word   = word_fm;
    end

    always_comb
    begin
        open_next = open_reg;
        len_next  = len_reg;
        if (q_write)
        begin
            open_next = !closes;
            len_next  = closes ? 8'd0 : len_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            len_reg  <= 8'd0;
        end
        else
        begin
            open_reg <= open_next;
            len_reg  <= len_next;
        end
    end

endmodule

### sv/sh24_queue.sv
// Short request queue between the front end and the round engine.
`timescale 1ns / 1ps

module sh24_queue
    import sh24_pkg::*;
#(
    parameter int unsigned Depth = QUEUE_DEPTH   // 2 and up
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr,
    input  sh24_cmd_t   wr_cmd,
    input  logic        rd,
    output sh24_cmd_t   head,
    output sh24_qstat_t stat
);

    localparam int unsigned PtrW = $clog2(Depth);
    localparam int unsigned CntW = $clog2(Depth + 1);

    sh24_cmd_t       mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;
    logic            do_wr;
    logic            do_rd;

    assign stat.full  = (cnt_reg == CntW'(Depth));
    assign stat.empty = (cnt_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### sv/sh24_engine.sv
// Back end: one SipRound per cycle while a request waits, result register towards the reader.
`timescale 1ns / 1ps

module sh24_engine
    import sh24_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  sh24_cmd_t         cmd,
    input  sh24_qstat_t       q_stat,
    input  logic [WORD_W-1:0] key_low,
    input  logic [WORD_W-1:0] key_high,
    input  logic              pop,
    output logic              empty,
    output logic [WORD_W-1:0] hash_value,
    output sh24_estat_t       stat
);

    typedef enum logic [2:0] {
        PH_NEW,
        PH_A1,
        PH_F0,
        PH_F1,
        PH_R
    } phase_t;

    typedef enum logic [2:0] {
        ST_A0,
        ST_A1,
        ST_F0,
        ST_F1,
        ST_R
    } step_t;

    phase_t            ph_reg;
    phase_t            ph_next;
    logic [1:0]        rcnt_reg;
    logic [1:0]        rcnt_next;
    sh24_state_t       v_reg;
    sh24_state_t       v_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    logic [WORD_W-1:0] res_reg;
    logic [WORD_W-1:0] res_next;

    step_t             step;
    sh24_state_t       v_in;
    sh24_state_t       v_pre;
    sh24_state_t       v_rnd;
    sh24_state_t       v_post;
    sh24_state_t       v_init;
    logic [WORD_W-1:0] mblk;
    logic              last_step;
    logic              go;
    logic              done;

    assign v_init[0] = SIP_INIT0 ^ key_low;
    assign v_init[1] = SIP_INIT1 ^ key_high;
    assign v_init[2] = SIP_INIT2 ^ key_low;
    assign v_init[3] = SIP_INIT3 ^ key_high;

    always_comb
    begin
        unique case (ph_reg)
            PH_NEW:  step = cmd.absorb ? ST_A0 : ST_F0;
            PH_A1:   step = ST_A1;
            PH_F0:   step = ST_F0;
            PH_F1:   step = ST_F1;
            PH_R:    step = ST_R;
            default: step = ST_R;
        endcase
    end

    assign last_step = (step == ST_R) && (rcnt_reg == 2'd3);
    // hold the last round while the previous hash still waits
    assign go        = !q_stat.empty && !(last_step && res_valid_reg && !pop);
    assign done      = (step == ST_A1 && !cmd.fin) || last_step;

    always_comb
    begin
        v_in = (ph_reg == PH_NEW && cmd.start) ? v_init : v_reg;
        if (step == ST_A0 || step == ST_A1)
        begin
            mblk = cmd.word;
        end
        else
        begin
            mblk = {cmd.len, 56'd0} | (cmd.absorb ? '0 : cmd.word);
        end
        v_pre = v_in;
        if (step == ST_A0 || step == ST_F0)
        begin
            v_pre[3] = v_in[3] ^ mblk;
        end
        v_rnd  = sip_round(v_pre);
        v_post = v_rnd;
        if (step == ST_A1 || step == ST_F1)
        begin
            v_post[0] = v_rnd[0] ^ mblk;
        end
        if (step == ST_F1)
        begin
            v_post[2] = v_rnd[2] ^ SIP_FINAL_XOR;
        end
    end

    always_comb
    begin
        ph_next        = ph_reg;
        rcnt_next      = rcnt_reg;
        v_next         = v_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        if (go)
        begin
            v_next = v_post;
            unique case (step)
                ST_A0: ph_next = PH_A1;
                ST_A1: ph_next = cmd.fin ? PH_F0 : PH_NEW;
                ST_F0: ph_next = PH_F1;
                ST_F1:
                begin
                    ph_next   = PH_R;
                    rcnt_next = 2'd0;
                end
                ST_R:
                begin
                    rcnt_next = rcnt_reg + 2'd1;
                    if (last_step)
                    begin
                        ph_next        = PH_NEW;
                        res_next       = v_post[0] ^ v_post[1] ^ v_post[2] ^ v_post[3];
                        res_valid_next = 1'b1;
                    end
                end
                default: ph_next = PH_NEW;
            endcase
        end
    end

    assign stat.pop       = go && done;
    assign stat.res_write = go && last_step;
    assign empty          = !res_valid_reg;
    assign hash_value     = res_reg;

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg        <= PH_NEW;
            rcnt_reg      <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ph_reg        <= ph_next;
            rcnt_reg      <= rcnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

### sv/siphash_2_4_keyed_hash_core.sv
// SipHash-2-4 keyed hash core: top level with configuration registers.
// Usage:
//   Input queue side: drive data_word (first byte in bits 7:0), byte_count
//   (0 to 8, above 8 reads as 8) and last_word with push; the request is taken
//   when push is high and full is low. A count below 8 always ends the message.
//   Result side: while empty is low, hash_value holds the oldest hash; pop takes it.
//   Configuration: APB at 8-byte spacing: key_low, key_high, fold_case. Write
//   only while the core is idle.
// Timing:
//   A full word costs two SipRounds, a short closing item six and a full closing
//   item eight. The engine runs one round per cycle while a request waits and
//   no unread hash holds the final round. The hash is registered and appears
//   in the cycle after the last round.
//   The front end keeps taking items into a 4-deep request queue while the
//   engine works; full rises only when that queue is full.
// Stalls and reset:
//   If a hash still waits unread, the engine holds its final round, the queue
//   fills and then full stops the writer. Reset empties queue and result,
//   closes any open message and clears keys and fold_case.
`timescale 1ns / 1ps

module siphash_2_4_keyed_hash_core
    import sh24_pkg::*;
#(
    parameter int unsigned QueueDepth = QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [WORD_W-1:0] data_word,
    input  logic [3:0]        byte_count,
    input  logic              last_word,
    output logic              empty,
    input  logic              pop,
    output logic [WORD_W-1:0] hash_value,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0] pwdata,
    output logic [WORD_W-1:0] prdata,
    output logic              pready
);

    logic [WORD_W-1:0] key_low_reg;
    logic [WORD_W-1:0] key_low_next;
    logic [WORD_W-1:0] key_high_reg;
    logic [WORD_W-1:0] key_high_next;
    logic              fold_reg;
    logic              fold_next;
    logic              cfg_wr;
    logic [1:0]        reg_idx;

    sh24_qstat_t       q_stat;
    sh24_estat_t       e_stat;
    sh24_cmd_t         q_cmd;
    sh24_cmd_t         q_head;
    logic              q_write;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:3];
    assign full    = q_stat.full;

    always_comb
    begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        fold_next     = fold_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_KEY_LOW:   key_low_next  = pwdata;
                REG_KEY_HIGH:  key_high_next = pwdata;
                REG_FOLD_CASE: fold_next     = pwdata[0];
                default:       fold_next     = fold_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KEY_LOW:   prdata = key_low_reg;
            REG_KEY_HIGH:  prdata = key_high_reg;
            REG_FOLD_CASE: prdata = {{(WORD_W-1){1'b0}}, fold_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            fold_reg     <= 1'b0;
        end
        else
        begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
            fold_reg     <= fold_next;
        end
    end

    sh24_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last_word  (last_word),
        .fold_case  (fold_reg),
        .q_stat     (q_stat),
        .q_write    (q_write),
        .q_cmd      (q_cmd)
    );

    sh24_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_write),
        .wr_cmd (q_cmd),
        .rd     (e_stat.pop),
        .head   (q_head),
        .stat   (q_stat)
    );

    sh24_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (q_head),
        .q_stat     (q_stat),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .pop        (pop),
        .empty      (empty),
        .hash_value (hash_value),
        .stat       (e_stat)
    );

`ifndef SYNTH
    a_pop_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        e_stat.pop |-> !q_stat.empty)
        else $error("engine retired a request from an empty queue");

    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        e_stat.res_write |-> (empty || pop))
        else $error("hash written over an unread result");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        e_stat.res_write |=> !empty)
        else $error("finished hash not presented");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for the SipHash-2-4 keyed hash core.
`timescale 1ns / 1ps

module tb;
    import sh24_pkg::*;

    localparam int unsigned NUM_PHASES    = 9;
    localparam int unsigned PHASE_WORDS   = 118;
    localparam int unsigned SETTLE_CYCLES = 50;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned STALL_LIMIT   = 5000;

    typedef struct {
        logic [WORD_W-1:0] data;
        logic [3:0]        count;
        logic              last;
    } word_req_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              push       = 1'b0;
    logic              full;
    logic [WORD_W-1:0] data_word  = '0;
    logic [3:0]        byte_count = '0;
    logic              last_word  = 1'b0;
    logic              empty;
    logic              pop        = 1'b0;
    logic [WORD_W-1:0] hash_value;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [WORD_W-1:0] pwdata     = '0;
    logic [WORD_W-1:0] prdata;
    logic              pready;

    siphash_2_4_keyed_hash_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last_word  (last_word),
        .empty      (empty),
        .pop        (pop),
        .hash_value (hash_value),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state and its copy of the registers
    logic [WORD_W-1:0] key_lo_cfg = '0;
    logic [WORD_W-1:0] key_hi_cfg = '0;
    logic              fold_cfg   = 1'b0;
    logic [WORD_W-1:0] sip_v [4];
    logic [7:0]        msg_len    = '0;
    logic              msg_open   = 1'b0;

    word_req_t         req_queue[$];
    logic [WORD_W-1:0] hashes_due[$];

    int unsigned send_idle_pct  = 36;
    int unsigned recv_idle_pct  = 64;
    int unsigned rx_hold_reqs   = 0;
    int unsigned rx_hold_seen   = 0;
    int unsigned rx_hold_left   = 0;
    int unsigned errors         = 0;
    int unsigned words_queued   = 0;
    int unsigned words_taken    = 0;
    int unsigned hashes_checked = 0;
    int unsigned stall_cycles   = 0;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int unsigned b);
        return (x << b) | (x >> (WORD_W - b));
    endfunction

    function automatic void mix_round();
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        a = sip_v[0];
        b = sip_v[1];
        c = sip_v[2];
        d = sip_v[3];
        a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
        c = c + d; d = rotl(d, 16); d = d ^ c;
        a = a + d; d = rotl(d, 21); d = d ^ a;
        c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
        sip_v[0] = a;
        sip_v[1] = b;
        sip_v[2] = c;
        sip_v[3] = d;
    endfunction

    function automatic void absorb_block(input logic [WORD_W-1:0] m);
        sip_v[3] = sip_v[3] ^ m;
        mix_round();
        mix_round();
        sip_v[0] = sip_v[0] ^ m;
    endfunction

    function automatic logic [WORD_W-1:0] close_message(input logic [WORD_W-1:0] tail);
        absorb_block({msg_len, 56'd0} | tail);
        sip_v[2] = sip_v[2] ^ SIP_FINAL_XOR;
        repeat (4) mix_round();
        return sip_v[0] ^ sip_v[1] ^ sip_v[2] ^ sip_v[3];
    endfunction

    // advance the predictor by one word; returns 1 when a hash is due
    function automatic bit predict_hash(input logic [WORD_W-1:0] word_in,
                                        input logic [3:0] count_in,
                                        input logic last_in,
                                        output logic [WORD_W-1:0] h);
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] keep;
        logic [7:0]        b;
        int unsigned       cnt;
        w   = word_in;
        cnt = (count_in > 4'd8) ? 8 : count_in;
        h   = '0;
        if (fold_cfg)
        begin
            for (int i = 0; i < 8; i++)
            begin
                b = w[8*i +: 8];
                if (b >= 8'h41 && b <= 8'h5a)
                    w[8*i +: 8] = b + 8'h20;
            end
        end
        if (!msg_open)
        begin
            sip_v[0] = SIP_INIT0 ^ key_lo_cfg;
            sip_v[1] = SIP_INIT1 ^ key_hi_cfg;
            sip_v[2] = SIP_INIT2 ^ key_lo_cfg;
            sip_v[3] = SIP_INIT3 ^ key_hi_cfg;
            msg_len  = '0;
            msg_open = 1'b1;
        end
        if (cnt == 8)
        begin
            absorb_block(w);
            msg_len = msg_len + 8'd8;
            if (!last_in)
                return 1'b0;
            h = close_message('0);
        end
        else
        begin
            keep    = (cnt == 0) ? '0 : ({WORD_W{1'b1}} >> (WORD_W - 8 * cnt));
            msg_len = msg_len + 8'(cnt);
            h       = close_message(w & keep);
        end
        msg_open = 1'b0;
        msg_len  = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    // driver: take the request at the rising edge, offer the next at the falling edge
    always @(posedge clk)
    begin
        logic [WORD_W-1:0] h;
        if (rst_n && push && !full)
        begin
            if (predict_hash(data_word, byte_count, last_word, h))
                hashes_due.push_back(h);
            void'(req_queue.pop_front());
            words_taken++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && req_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            push       <= 1'b1;
            data_word  <= req_queue[0].data;
            byte_count <= req_queue[0].count;
            last_word  <= req_queue[0].last;
        end
        else
            push <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        logic [WORD_W-1:0] want;
        if (rst_n && pop && !empty)
        begin
            if (hashes_due.size() == 0)
                report_mismatch("hash with none due", hash_value, '0);
            else
            begin
                want = hashes_due.pop_front();
                if (hash_value !== want)
                    report_mismatch("hash_value", hash_value, want);
            end
            hashes_checked++;
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold_reqs != rx_hold_seen)
        begin
            rx_hold_seen = rx_hold_reqs;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [WORD_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_KEY_LOW:   key_lo_cfg = val;
            REG_KEY_HIGH:  key_hi_cfg = val;
            REG_FOLD_CASE: fold_cfg   = val[0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [WORD_W-1:0] klo, input logic [WORD_W-1:0] khi,
                              input logic fold);
        write_reg(REG_KEY_LOW, klo);
        write_reg(REG_KEY_HIGH, khi);
        write_reg(REG_FOLD_CASE, {63'd0, fold});
    endtask

    task automatic queue_word(input logic [WORD_W-1:0] d, input logic [3:0] c, input logic l);
        word_req_t r;
        r.data  = d;
        r.count = c;
        r.last  = l;
        req_queue.push_back(r);
        words_queued++;
    endtask

    // hold until every request is taken and every hash is back, then let the engine settle
    task automatic wait_drained();
        while (req_queue.size() != 0 || hashes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] w;
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(0, 3))
                0:       w[8*i +: 8] = 8'($urandom_range(8'h40, 8'h5b));
                1:       w[8*i +: 8] = 8'($urandom_range(8'h60, 8'h7b));
                default: w[8*i +: 8] = 8'($urandom);
            endcase
        end
        return w;
    endfunction

    function automatic logic [3:0] full_count();
        return ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
    endfunction

    task automatic queue_message(input int unsigned n_full, input bit closed);
        for (int unsigned i = 0; i < n_full; i++)
            queue_word(rand_word(), full_count(), 1'b0);
        if (closed)
        begin
            if ($urandom_range(0, 3) != 0)
                queue_word(rand_word(), 4'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            else
                queue_word(rand_word(), full_count(), 1'b1);
        end
    endtask

    initial
    begin
        int unsigned       phase_start;
        int unsigned       n_full;
        logic [WORD_W-1:0] klo;
        logic [WORD_W-1:0] khi;
        logic              fold;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words with keys and fold as reset left them
        queue_word({WORD_W{1'b1}}, 4'd0, 1'b0);
        queue_word('0, 4'd0, 1'b1);
        queue_word(64'h0706050403020100, 4'd8, 1'b1);
        queue_word({WORD_W{1'b1}}, 4'd8, 1'b0);
        queue_word({WORD_W{1'b1}}, 4'd7, 1'b0);
        queue_word(64'h0123456789abcdef, 4'd15, 1'b1);
        queue_word(64'hfedcba9876543210, 4'd9, 1'b0);
        queue_word(64'h5a5a5a5a5a5a5a5a, 4'd3, 1'b1);
        queue_word('0, 4'd8, 1'b0);
        queue_word({WORD_W{1'b1}}, 4'd8, 1'b1);
        queue_word(64'hffffffffffffff41, 4'd1, 1'b0);
        wait_drained();

        // extreme keys and case folding around the letter boundaries
        set_config({WORD_W{1'b1}}, {WORD_W{1'b1}}, 1'b1);
        queue_word(64'h7b7a61605b5a4140, 4'd8, 1'b0);
        queue_word(64'h5a47464544434241, 4'd7, 1'b1);
        queue_word(64'h4141414141414141, 4'd8, 1'b1);
        queue_word(64'hffffffffffff5a41, 4'd2, 1'b0);
        queue_word(64'h524f574f4c4c4548, 4'd8, 1'b0);
        wait_drained();

        // keys change under an open message: the next message picks them up
        for (int unsigned ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph / 3)
                0:       begin send_idle_pct = 36; recv_idle_pct = 64; end
                1:       begin send_idle_pct = 64; recv_idle_pct = 36; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            case (ph % 4)
                0:       begin klo = '0; khi = '0; fold = 1'b0; end
                1:       begin klo = {WORD_W{1'b1}}; khi = {WORD_W{1'b1}}; fold = 1'b1; end
                2:       begin klo = {$urandom, $urandom}; khi = '0; fold = 1'b1; end
                default: begin
                    klo  = {$urandom, $urandom};
                    khi  = {$urandom, $urandom};
                    fold = 1'($urandom_range(0, 1));
                end
            endcase
            set_config(klo, khi, fold);
            phase_start = words_queued;
            while (words_queued - phase_start < PHASE_WORDS)
            begin
                n_full = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 40)
                                                      : $urandom_range(0, 3);
                queue_message(n_full, 1'b1);
            end
            if (ph + 1 < NUM_PHASES && $urandom_range(0, 1) == 1)
                queue_message($urandom_range(1, 2), 1'b0);
            if (ph == 6)
                rx_hold_reqs++;
            wait_drained();
        end

        $display("Covered %0d words and %0d hashes over %0d key and fold settings,",
                 words_taken, hashes_checked, NUM_PHASES + 2);
        $display("with receiver hold-off, sender pauses and keys changed under open messages.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
sv/sh24_pkg.sv
sv/sh24_front.sv
sv/sh24_queue.sv
sv/sh24_engine.sv
sv/siphash_2_4_keyed_hash_core.sv
tb/tb.sv
